[rtl/core/pcm_int16_float32_converter_defines.svh]
// Assertion macros used by the checker file of the PCM sample converter.
// No dependencies.
`ifndef PCM_INT16_FLOAT32_CONVERTER_DEFINES_SVH
`define PCM_INT16_FLOAT32_CONVERTER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define PCM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define PCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/pcmcv_pkg.sv]
// Package for the PCM int16/float32 sample converter.
// Holds widths, direction codes, the constant 32767 and the pipe depth. No dependencies.
package pcmcv_pkg;
  localparam int SampleWidth = 32;
  localparam logic DirIntToFloat = 1'b0;
  localparam logic DirFloatToInt = 1'b1;
  localparam logic [14:0] FullScale = 15'd32767;
  localparam int PipeDepth = 4;
endpackage

[rtl/core/pcm_int16_float32_converter.sv]
// Converts PCM samples between int16 and float32 at one item per clock, with
// conv_direction choosing the direction (write it only while idle). There are
// four register stages: decode, 39-bit multiply, normalize/round, and
// shift/pack. An accepted item moves through these registers in order, and
// its result is registered at the outputs. All stages advance together
// whenever the final stage is empty or its result is being taken. A stalled
// result therefore freezes the whole pipe, and in_ready stays low until the
// result is taken.
module pcm_int16_float32_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] sample_bits,
  input  logic        last_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] sample_out,
  output logic        last_out
);

  logic conv_direction;
  logic [pcmcv_pkg::PipeDepth-1:0] vld;
  logic adv;
  assign adv = !vld[pcmcv_pkg::PipeDepth-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[pcmcv_pkg::PipeDepth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      conv_direction <= pcmcv_pkg::DirIntToFloat;
      vld <= '0;
    end else begin
      if (cfg_we) conv_direction <= cfg_wdata;
      if (adv) vld <= {vld[pcmcv_pkg::PipeDepth-2:0], in_valid};
    end
  end

  // Stage 1: decode.
  logic        s1_dir, s1_last, s1_sign, s1_nan, s1_sat, s1_zero;
  logic [23:0] s1_sig;
  logic [7:0]  s1_sh;   // right shift of the product, 24..149 when not saturated
  logic [15:0] s1_mag;  // integer magnitude for int-to-float
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dir  <= conv_direction;
      s1_last <= last_in;
      s1_sign <= (conv_direction == pcmcv_pkg::DirIntToFloat) ? sample_bits[15]
                                                             : sample_bits[31];
      s1_mag  <= sample_bits[15] ? 16'(~sample_bits[15:0] + 16'd1) : sample_bits[15:0];
      s1_nan  <= (sample_bits[30:23] == 8'hFF) && (sample_bits[22:0] != '0);
      s1_sat  <= sample_bits[30:23] >= 8'd127;
      s1_zero <= (sample_bits[30:0] == '0);
      s1_sig  <= (sample_bits[30:23] == 8'd0) ? {1'b0, sample_bits[22:0]}
                                              : {1'b1, sample_bits[22:0]};
      s1_sh   <= (sample_bits[30:23] == 8'd0) ? 8'd149 : 8'(8'd150 - sample_bits[30:23]);
    end
  end

  // Stage 2: product and int-to-float leading-one position.
  logic        s2_dir, s2_last, s2_sign, s2_nan, s2_sat, s2_zero;
  logic [38:0] s2_q;
  logic [7:0]  s2_sh;
  logic [15:0] s2_mag;
  logic [3:0]  s2_p;
  logic [3:0]  p_c;
  always_comb begin
    p_c = '0;
    for (int i = 0; i < 16; i++)
      if (s1_mag[i]) p_c = 4'(i);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_dir <= s1_dir; s2_last <= s1_last; s2_sign <= s1_sign;
      s2_nan <= s1_nan; s2_sat <= s1_sat; s2_zero <= s1_zero;
      s2_q   <= 39'(s1_sig) * 39'(pcmcv_pkg::FullScale);
      s2_sh  <= s1_sh;
      s2_mag <= s1_mag;
      s2_p   <= s1_mag[15] ? 4'd15 : p_c;
    end
  end

  // Stage 3: round product to 24 bits (nearest even); build float word.
  logic        s3_dir, s3_last, s3_sign, s3_nan, s3_sat;
  logic [24:0] s3_q;
  logic [7:0]  s3_sh;
  logic [31:0] s3_flt;
  logic [5:0]  len_c, k_c;
  logic [38:0] low_c, half_c, mask_c;
  logic [24:0] qs_c;
  logic [38:0] qsh_c;
  logic [22:0] frac_c;
  always_comb begin
    len_c = '0;
    for (int i = 0; i < 39; i++)
      if (s2_q[i]) len_c = 6'(i + 1);
    k_c    = (len_c > 6'd24) ? 6'(len_c - 6'd24) : 6'd0;
    mask_c = (39'd1 << k_c) - 39'd1;
    low_c  = s2_q & mask_c;
    half_c = (k_c == 6'd0) ? 39'd0 : (39'd1 << (k_c - 6'd1));
    qsh_c  = s2_q >> k_c;
    qs_c   = qsh_c[24:0];
    if (k_c != 6'd0 && (low_c > half_c || (low_c == half_c && qs_c[0])))
      qs_c = qs_c + 25'd1;
    frac_c = 23'({7'd0, s2_mag} << (5'd23 - 5'(s2_p)));
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_dir <= s2_dir; s3_last <= s2_last; s3_sign <= s2_sign;
      s3_nan <= s2_nan || s2_zero; s3_sat <= s2_sat;
      s3_q   <= qs_c;
      s3_sh  <= 8'(s2_sh - {2'd0, k_c});
      s3_flt <= (s2_mag == '0) ? 32'd0
              : {s2_sign, 8'(8'd112 + {4'd0, s2_p}), frac_c};
    end
  end

  // Stage 4: final shift, clamp, sign, output select.
  logic [24:0] t_c;
  logic [14:0] tc_c;
  logic [15:0] i16_c;
  logic [31:0] res_c;
  always_comb begin
    t_c  = (s3_sh >= 8'd25) ? 25'd0 : (s3_q >> s3_sh[4:0]);
    tc_c = (t_c > 25'd32767) ? pcmcv_pkg::FullScale : t_c[14:0];
    if (s3_sat) tc_c = pcmcv_pkg::FullScale;
    if (s3_nan) tc_c = '0;
    i16_c = s3_sign ? 16'(17'h10000 - {2'd0, tc_c}) : {1'b0, tc_c};
    res_c = (s3_dir == pcmcv_pkg::DirIntToFloat) ? s3_flt : {16'd0, i16_c};
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sample_out <= res_c;
      last_out   <= s3_last;
    end
  end

endmodule

[rtl/core/pcmcv_checker.sv]
// Port-level checker for the PCM sample converter, bound to the top level.
// Depends on pcm_int16_float32_converter_defines.svh.
`include "pcm_int16_float32_converter_defines.svh"
module pcmcv_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] sample_out
);
  // A stalled result holds its value.
  `PCM_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(sample_out), "result changed while stalled")
  // The pipe always has room when the output is free.
  `PCM_ASSERT_IMPL(a_ready, clk, rst, !out_valid || out_ready, in_ready, "input blocked with free output")
  // A stall reaches the input side.
  `PCM_ASSERT_IMPL(a_stall, clk, rst, out_valid && !out_ready, !in_ready, "input taken during stall")
endmodule

bind pcm_int16_float32_converter pcmcv_checker u_pcmcv_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .sample_out(sample_out)
);

[test/testbench.sv]
// Testbench for the PCM int16/float32 sample converter.
// Depends on pcmcv_pkg and pcm_int16_float32_converter; predicts each result itself.
`timescale 1ns / 100ps

module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] sample_bits = '0;
  logic        last_in = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] sample_out;
  logic        last_out;

  logic        direction = pcmcv_pkg::DirIntToFloat;
  logic [32:0] expected_samples[$];
  int          mismatches = 0;
  int          cycles = 0;

  localparam int CycleLimit = 200000;

  pcm_int16_float32_converter DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .sample_bits(sample_bits),
    .last_in(last_in), .out_valid(out_valid), .out_ready(out_ready),
    .sample_out(sample_out), .last_out(last_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] int_to_float(logic [31:0] raw);
    logic [15:0] v;
    logic [16:0] mag;
    logic [31:0] sign;
    int p;
    v = raw[15:0];
    sign = 0;
    if (v == 0) return 32'd0;
    if (v[15]) begin
      sign = 32'h8000_0000;
      mag = 17'h10000 - {1'b0, v};
    end else begin
      mag = {1'b0, v};
    end
    p = 15;
    while (p > 0 && mag[p] == 1'b0) p--;
    return sign | ((p + 112) << 23) | ((32'(mag) << (23 - p)) & 32'h7F_FFFF);
  endfunction

  function automatic logic [31:0] float_to_int(logic [31:0] x);
    logic [7:0] ex;
    logic [22:0] man;
    logic [63:0] q, low, half;
    int len, k, sh;
    logic [31:0] t;
    ex = x[30:23];
    man = x[22:0];
    k = 0;
    if (ex == 8'hFF && man != 0) return 32'd0;
    if (ex >= 127) return x[31] ? 32'h8001 : 32'h7FFF;
    if (ex == 0) begin
      q = 64'(man);
      sh = 149;
    end else begin
      q = 64'({1'b1, man});
      sh = 150 - ex;
    end
    q = q * 64'(pcmcv_pkg::FullScale);
    if (q == 0) return 32'd0;
    len = 0;
    while (len < 64 && (q >> len) != 0) len++;
    if (len > 24) begin
      k = len - 24;
      low = q & ((64'd1 << k) - 1);
      half = 64'd1 << (k - 1);
      q = q >> k;
      if (low > half || (low == half && q[0])) q++;
    end
    sh -= k;
    t = (sh >= 64) ? 32'd0 : 32'(q >> sh);
    if (t > 32767) t = 32767;
    if (x[31]) t = (32'h10000 - t) & 32'hFFFF;
    return t;
  endfunction

  // Valid stays high into the next item when that item follows with no gap.
  task automatic send_sample(logic [31:0] bits, logic last);
    int idle;
    idle = $urandom_range(0, 4);
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample_bits <= bits;
    last_in <= last;
    expected_samples.push_back({last,
      direction == pcmcv_pkg::DirIntToFloat ? int_to_float(bits) : float_to_int(bits)});
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (2 * pcmcv_pkg::PipeDepth) @(negedge clk);
  endtask

  task automatic set_direction(logic dir);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= dir;
    direction = dir;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Consumer: random stall per item, compare against the oldest prediction.
  initial begin
    int stall;
    logic [32:0] want;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected item %h", sample_out);
        end else begin
          want = expected_samples.pop_front();
          if (want != {last_out, sample_out}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %h last %b, got %h last %b",
                       want[31:0], want[32], sample_out, last_out);
          end
        end
        stall = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) stall = 0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_int_directed();
    set_direction(pcmcv_pkg::DirIntToFloat);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h0000_0001, 1'b1);
    send_sample(32'h0000_7FFF, 1'b0);
    send_sample(32'h0000_8000, 1'b1);
    send_sample(32'h0000_FFFF, 1'b0);
    send_sample(32'hFFFF_0000, 1'b0);
    send_sample(32'hABCD_4000, 1'b1);
  endtask

  task automatic test_float_directed();
    set_direction(pcmcv_pkg::DirFloatToInt);
    send_sample(32'h3F80_0000, 1'b0); // +1.0
    send_sample(32'hBF80_0000, 1'b1); // -1.0
    send_sample(32'h7F80_0000, 1'b0); // +inf
    send_sample(32'hFF80_0000, 1'b0); // -inf
    send_sample(32'h7FC0_0000, 1'b1); // NaN
    send_sample(32'hFFFF_FFFF, 1'b0); // NaN
    send_sample(32'h8000_0000, 1'b0); // negative zero
    send_sample(32'h0000_0001, 1'b0); // subnormal
    send_sample(32'h3F7F_FFFF, 1'b1); // just below one
    send_sample(32'h3F00_0000, 1'b0); // half
    send_sample(32'h3800_0000, 1'b0); // near one LSB
    send_sample(32'h4B00_0000, 1'b1); // large
  endtask

  task automatic test_random(int count);
    logic [31:0] bits;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) set_direction(1'($urandom_range(0, 1)));
      if (i == count / 2) drain(); // sender waits for every result
      bits = $urandom();
      // Mostly in-range floats so the rounding path is exercised.
      if (direction == pcmcv_pkg::DirFloatToInt && $urandom_range(0, 3) != 0)
        bits[30:23] = 8'($urandom_range(100, 127));
      send_sample(bits, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    test_int_directed();
    test_float_directed();
    test_random(900);
    set_direction(pcmcv_pkg::DirIntToFloat);
    drain();
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/pcmcv_pkg.sv
rtl/core/pcm_int16_float32_converter.sv
rtl/core/pcmcv_checker.sv
test/testbench.sv
